>>> rtl/capability_check_cache_core_macros.svh
// Assertion macros shared by the checker of capability_check_cache_core.
// Each macro expands to one labeled concurrent assertion on aclk.
`ifndef CAPABILITY_CHECK_CACHE_CORE_MACROS_SVH
`define CAPABILITY_CHECK_CACHE_CORE_MACROS_SVH

// Implication checked only outside reset.
`define CCC_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked at every edge, reset included.
`define CCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/ccc_pkg.sv
`timescale 1ns / 1ps
// Package for the capability check cache: sizes, register indexes, types.
// Used by ccc_cfg, capability_check_cache_core and ccc_checker; depends on nothing.
package ccc_pkg;

    localparam int CACHE_SLOTS = 16;
    localparam int SLOT_IDX_W  = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

    localparam logic [39:0] TTL_RESET   = 40'd1000000;
    localparam logic [16:0] TABLE_RESET = 17'd1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL           = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd2;

    localparam logic REQ_VERIFY = 1'b0;
    localparam logic REQ_SWEEP  = 1'b1;

    localparam int IN_DATA_W  = 264;
    localparam int OUT_DATA_W = 200;

    typedef struct packed {
        logic        cache_enable;
        logic [39:0] ttl;
        logic [16:0] table_entries;
    } ccc_cfg_t;

    typedef struct packed {
        logic [63:0] stamp;
        logic        answer;
        logic [31:0] rights;
        logic [31:0] domain;
        logic [31:0] cap;
    } slot_entry_t;

    localparam int SLOT_W = $bits(slot_entry_t);

endpackage

>>> rtl/ccc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module ccc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         aclk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/ccc_cfg.sv
`timescale 1ns / 1ps
// Configuration register file of the capability check cache.
// Depends on ccc_pkg for register indexes and the configuration struct.
module ccc_cfg
    import ccc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output ccc_cfg_t              cfg
);

    ccc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cache_enable  <= 1'b0;
            cfg_reg.ttl           <= TTL_RESET;
            cfg_reg.table_entries <= TABLE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CACHE_ENABLE:  cfg_reg.cache_enable  <= cfg_data[0];
                CFG_TTL:           cfg_reg.ttl           <= cfg_data[39:0];
                CFG_TABLE_ENTRIES: cfg_reg.table_entries <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/capability_check_cache_core.sv
`timescale 1ns / 1ps
// Top level of the capability check cache: request sequencer, slot scan, counters.
// Depends on ccc_pkg, ccc_cfg and ccc_ram.
//
//  channel   direction  handshake                 contents
//  s_*       in         s_tvalid / s_tready       request, kind in s_tuser
//  m_*       out        m_tvalid / m_tready       answer and counters, hit in m_tuser
//  cfg_*     in         cfg_valid / cfg_ready     register index and data
//
// A direct check (cache disabled) goes from accept straight to ST_DONE.
// A cached verify or a sweep reads the slot RAM one slot at a time, passing
// through ST_READ and ST_CHECK for each slot; a hit ends the scan at that slot.
// Reset is synchronous; all slots are marked free at once, no clearing pass.
// A new request is taken while a finished result still waits on m_*; the next
// result waits in its final state until the output register is free.
module capability_check_cache_core
    import ccc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now, requesting domain, cap_id, needed rights mask, entry_cap_id,
    // entry_owner, entry_rights, entry_revoked, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // granted, hit_total, miss_total, verified_total, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // cache_hit
    output logic                  m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CHECK, ST_DONE} state_t;

    state_t                 state_reg;
    ccc_cfg_t               cfg;
    logic [CACHE_SLOTS-1:0] used_reg;
    logic [SLOT_IDX_W-1:0]  idx_reg;
    logic                   hit_reg;
    logic                   hit_ans_reg;

    logic        kind_reg;
    logic [63:0] now_reg;
    logic [31:0] dom_reg, cap_reg, need_reg, ecap_reg, eown_reg, erights_reg;
    logic        erev_reg;

    logic [63:0] hits_reg, misses_reg, verifies_reg;
    logic        m_valid_reg, m_granted_reg, m_hit_reg;

    slot_entry_t           rd_entry, wr_entry;
    logic [SLOT_W-1:0]     rd_bits;
    logic                  wr_en;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  free_found;
    logic [63:0]           age;
    logic                  match, direct_ok, out_free, last_slot;

    ccc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccc_ram #(.WIDTH(SLOT_W), .DEPTH(CACHE_SLOTS)) u_slots (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (free_idx),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_bits)
    );

    assign rd_entry  = slot_entry_t'(rd_bits);
    assign age       = now_reg - rd_entry.stamp;
    assign match     = used_reg[idx_reg] && rd_entry.cap == cap_reg &&
                       rd_entry.domain == dom_reg && rd_entry.rights == need_reg;
    assign last_slot = idx_reg == SLOT_IDX_W'(CACHE_SLOTS - 1);
    assign out_free  = !m_valid_reg || m_tready;

    assign direct_ok = ({15'd0, cap_reg} < {30'd0, cfg.table_entries}) &&
                       ecap_reg == cap_reg && !erev_reg && eown_reg == dom_reg &&
                       (erights_reg & need_reg) == need_reg;

    // Lowest free slot, from the valid bits after the scan.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx   = SLOT_IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign wr_entry = '{stamp: now_reg, answer: direct_ok, rights: need_reg,
                        domain: dom_reg, cap: cap_reg};
    assign wr_en    = state_reg == ST_DONE && out_free && kind_reg == REQ_VERIFY &&
                      cfg.cache_enable && !hit_reg && free_found;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_hit_reg;
    assign m_tdata  = {7'd0, verifies_reg, misses_reg, hits_reg, m_granted_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            hits_reg     <= '0;
            misses_reg   <= '0;
            verifies_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // In ST_DONE the output register is reloaded below instead.
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg    <= s_tuser;
                        now_reg     <= s_tdata[63:0];
                        dom_reg     <= s_tdata[95:64];
                        cap_reg     <= s_tdata[127:96];
                        need_reg    <= s_tdata[159:128];
                        ecap_reg    <= s_tdata[191:160];
                        eown_reg    <= s_tdata[223:192];
                        erights_reg <= s_tdata[255:224];
                        erev_reg    <= s_tdata[256];
                        idx_reg     <= '0;
                        hit_reg     <= 1'b0;
                        if (s_tuser == REQ_VERIFY && !cfg.cache_enable) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (kind_reg == REQ_SWEEP) begin
                        if (used_reg[idx_reg] && age > {24'd0, cfg.ttl}) begin
                            used_reg[idx_reg] <= 1'b0;
                        end
                    end else if (match) begin
                        if (age < {24'd0, cfg.ttl}) begin
                            hit_reg     <= 1'b1;
                            hit_ans_reg <= rd_entry.answer;
                        end else begin
                            used_reg[idx_reg] <= 1'b0;
                        end
                    end
                    if (last_slot || (kind_reg == REQ_VERIFY && match &&
                                      age < {24'd0, cfg.ttl})) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= idx_reg + SLOT_IDX_W'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        if (kind_reg == REQ_VERIFY && cfg.cache_enable && hit_reg) begin
                            m_granted_reg <= hit_ans_reg;
                            m_hit_reg     <= 1'b1;
                            hits_reg      <= hits_reg + 64'd1;
                        end else begin
                            m_granted_reg <= kind_reg == REQ_VERIFY && direct_ok;
                            m_hit_reg     <= 1'b0;
                            if (kind_reg == REQ_VERIFY && cfg.cache_enable) begin
                                misses_reg   <= misses_reg + 64'd1;
                                verifies_reg <= verifies_reg + 64'd1;
                                if (free_found) begin
                                    used_reg[free_idx] <= 1'b1;
                                end
                            end
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Counter outputs reflect the updated counters in the same transfer.
    // The loads above take effect together with the counter increments.

endmodule

>>> rtl/ccc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for capability_check_cache_core, bound to the top level.
// Depends on capability_check_cache_core_macros.svh and ccc_pkg.
`include "capability_check_cache_core_macros.svh"

module ccc_checker
    import ccc_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    // A stalled result stays offered.
    `CCC_ASSERT(a_out_hold, $past(m_tvalid && !m_tready) && aresetn && $past(aresetn), m_tvalid)
    // One request at a time: after a transfer in, the input side closes.
    `CCC_ASSERT_NEXT(a_one_at_a_time, aresetn && s_tvalid && s_tready, !s_tready)
    // Reset empties the output register and opens the input side.
    `CCC_ASSERT_NEXT(a_reset_state, !aresetn, !m_tvalid && s_tready)
    // While a result is stalled, its payload and hit flag stay put.
    `CCC_ASSERT(a_out_stable, $past(m_tvalid && !m_tready) && aresetn && $past(aresetn), $stable(m_tdata) && $stable(m_tuser))

endmodule

bind capability_check_cache_core ccc_checker u_ccc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
